[design/tgls_pkg.sv]
// Shared constants, level codes and controller/datapath interface types
// for the throughput guard level selector. No dependencies.
`default_nettype none

package tgls_pkg;

   // Window and sample sizing
   localparam int WINDOW_DEPTH = 8;
   localparam int RATE_WIDTH   = 16;

   // Derived widths
   localparam int SLOT_WIDTH  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_WIDTH   = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_WIDTH   = RATE_WIDTH + $clog2(WINDOW_DEPTH);
   localparam int DIV_WIDTH   = SUM_WIDTH + (SUM_WIDTH % 2);
   localparam int DIV_STEPS   = DIV_WIDTH / 2;
   localparam int STEP_WIDTH  = $clog2(DIV_STEPS);

   // Configuration port
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QFLOOR = 1'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] DEFAULT_TARGET = 16'd3840;
   localparam logic [CSR_DATA_WIDTH-1:0] DEFAULT_QFLOOR = 16'd218;

   // Comparison widths: values times a 7-bit factor
   localparam int VAL_WIDTH = (RATE_WIDTH > CSR_DATA_WIDTH) ? RATE_WIDTH : CSR_DATA_WIDTH;
   localparam int CMP_WIDTH = VAL_WIDTH + 7;
   localparam int QF_WIDTH  = CSR_DATA_WIDTH + 7;

   // Scaled factors: 0.75 = 3/4, 1.08 = 108/100, 0.85 in Q8.8 = 85*256/100
   localparam int SKIP_NUM  = 3;
   localparam int SKIP_DEN  = 4;
   localparam int ATTN_NUM  = 108;
   localparam int ATTN_DEN  = 100;
   localparam int QF_SCALE  = 100;
   localparam int QF_LIMIT  = 85 * 256;

   // Compute levels
   localparam logic [1:0] LEVEL_EXACT = 2'd0;
   localparam logic [1:0] LEVEL_ATTN  = 2'd1;
   localparam logic [1:0] LEVEL_SKIP  = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // take the sample, update ring, slot and fill count
      logic sum;       // update running sum, load divider
      logic div_step;  // two quotient bits
      logic decide;    // level and breach decision
      logic push;      // load the result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic div_last;  // current divider step is the final one
   } status_type;

endpackage

`default_nettype wire

[design/tgls_ctrl.sv]
// Sequencing state machine for the throughput guard: input handshake,
// phase control and result valid. Depends on tgls_pkg.
`default_nettype none

module tgls_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire tgls_pkg::status_type status,
   output tgls_pkg::cmd_type        cmd
);
   import tgls_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SUM    = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_PUSH   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   // Result register can take a transaction when empty or draining now
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_PUSH;
         end
         ST_PUSH: begin
            if (slot_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on push, held while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[design/tgls_dpath.sv]
// Datapath for the throughput guard: config registers, sample ring, running
// sum, radix-4 restoring divider, level decision and result register.
// Depends on tgls_pkg.
`default_nettype none

module tgls_dpath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire tgls_pkg::cmd_type                    cmd,
   output tgls_pkg::status_type                      status,
   input  wire logic [tgls_pkg::RATE_WIDTH-1:0]      req_rate_sample,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tgls_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [tgls_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output logic [1:0]                                rsp_compute_level,
   output logic                                      rsp_floor_breached,
   output logic [tgls_pkg::RATE_WIDTH-1:0]           rsp_average_rate
);
   import tgls_pkg::*;

   // Configuration
   logic [CSR_DATA_WIDTH-1:0] target_ff, qfloor_ff;

   // Ring and window bookkeeping
   logic [RATE_WIDTH-1:0] ring_mem [WINDOW_DEPTH];
   logic [RATE_WIDTH-1:0] old_ff;
   logic [RATE_WIDTH-1:0] sample_ff;
   logic                  evict_ff;
   logic [SLOT_WIDTH-1:0] slot_ff;
   logic [CNT_WIDTH-1:0]  fill_ff;
   logic [SUM_WIDTH-1:0]  sum_ff, sum_in;

   // Divider
   logic [DIV_WIDTH-1:0]  quo_ff, quo_in;
   logic [CNT_WIDTH-1:0]  rem_ff, rem_in;
   logic [STEP_WIDTH-1:0] step_ff;
   logic [CNT_WIDTH:0]    trial;

   // Decision
   logic [RATE_WIDTH-1:0] mean;
   logic [RATE_WIDTH-1:0] eff;
   logic [CMP_WIDTH-1:0]  eff_w, tgt_w, smp_w;
   logic                  below, skip_hit, attn_hit, qf_low;
   logic [1:0]            level_in, level_ff;
   logic                  breach_ff;

   // Result register
   logic [1:0]            rsp_level_ff;
   logic                  rsp_breach_ff;
   logic [RATE_WIDTH-1:0] rsp_avg_ff;

   // Config writes; zero selects the default
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= DEFAULT_TARGET;
         qfloor_ff <= DEFAULT_QFLOOR;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_TARGET) begin
            target_ff <= (csr_data == '0) ? DEFAULT_TARGET : csr_data;
         end
         if (csr_index == CSR_QFLOOR) begin
            qfloor_ff <= (csr_data == '0) ? DEFAULT_QFLOOR : csr_data;
         end
      end
   end

   // Ring memory: read the entry being overwritten, then write the sample
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         old_ff            <= ring_mem[slot_ff];
         ring_mem[slot_ff] <= req_rate_sample;
         sample_ff         <= req_rate_sample;
      end
   end

   // Slot, fill count and eviction flag
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         fill_ff  <= '0;
         evict_ff <= 1'b0;
      end else if (cmd.capture) begin
         evict_ff <= (fill_ff == CNT_WIDTH'(WINDOW_DEPTH));
         if (slot_ff == SLOT_WIDTH'(WINDOW_DEPTH - 1)) begin
            slot_ff <= '0;
         end else begin
            slot_ff <= slot_ff + 1'b1;
         end
         if (fill_ff != CNT_WIDTH'(WINDOW_DEPTH)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   // Running sum over the filled entries
   always_comb begin
      sum_in = sum_ff + SUM_WIDTH'(sample_ff);
      if (evict_ff) begin
         sum_in = sum_in - SUM_WIDTH'(old_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (cmd.sum) begin
         sum_ff <= sum_in;
      end
   end

   // Two restoring division steps per cycle, divisor is the fill count
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int k = 0; k < 2; k++) begin
         trial = {rem_in, quo_in[DIV_WIDTH-1]};
         if (trial >= {1'b0, fill_ff}) begin
            trial  = trial - {1'b0, fill_ff};
            quo_in = {quo_in[DIV_WIDTH-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[DIV_WIDTH-2:0], 1'b0};
         end
         rem_in = trial[CNT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         quo_ff  <= DIV_WIDTH'(sum_in);
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
         step_ff <= step_ff + 1'b1;
      end
   end

   assign status.div_last = (step_ff == STEP_WIDTH'(DIV_STEPS - 1));

   // Level decision; a zero mean falls back to the sample
   assign mean  = quo_ff[RATE_WIDTH-1:0];
   assign eff   = (mean == '0) ? sample_ff : mean;
   assign eff_w = CMP_WIDTH'(eff);
   assign tgt_w = CMP_WIDTH'(target_ff);
   assign smp_w = CMP_WIDTH'(sample_ff);

   assign below    = (smp_w < tgt_w) || (eff_w < tgt_w);
   assign skip_hit = (eff_w * CMP_WIDTH'(SKIP_DEN)) < (tgt_w * CMP_WIDTH'(SKIP_NUM));
   assign attn_hit = (eff_w * CMP_WIDTH'(ATTN_DEN)) < (tgt_w * CMP_WIDTH'(ATTN_NUM));
   assign qf_low   = (QF_WIDTH'(qfloor_ff) * QF_WIDTH'(QF_SCALE)) < QF_WIDTH'(QF_LIMIT);

   always_comb begin
      priority if (below) begin
         level_in = skip_hit ? LEVEL_SKIP : LEVEL_ATTN;
      end else if (attn_hit) begin
         level_in = LEVEL_ATTN;
      end else begin
         level_in = qf_low ? LEVEL_ATTN : LEVEL_EXACT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= LEVEL_EXACT;
         breach_ff <= 1'b0;
      end else if (cmd.decide) begin
         level_ff <= level_in;
         if (below) begin
            breach_ff <= 1'b1;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_level_ff  <= level_ff;
         rsp_breach_ff <= breach_ff;
         rsp_avg_ff    <= mean;
      end
   end

   assign rsp_compute_level  = rsp_level_ff;
   assign rsp_floor_breached = rsp_breach_ff;
   assign rsp_average_rate   = rsp_avg_ff;

endmodule

`default_nettype wire

[design/throughput_guard_level_select.sv]
// Throughput guard level selector: from request accept, the sum, divide, decide
// and push states run before rsp_valid; a new request is taken the cycle after the
// result is loaded, so no request is accepted while the last is being computed.
// The divider takes two quotient bits per cycle over the running window sum.
// A stalled result holds the next one in its load phase, req_stall high.
// Synchronous reset clears the window, sum and breach flag, and loads config defaults.
`default_nettype none

module throughput_guard_level_select (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [tgls_pkg::RATE_WIDTH-1:0]      req_rate_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [1:0]                                rsp_compute_level,
   output logic                                      rsp_floor_breached,
   output logic [tgls_pkg::RATE_WIDTH-1:0]           rsp_average_rate,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tgls_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [tgls_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import tgls_pkg::*;

   cmd_type    cmd;
   status_type status;

   tgls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tgls_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_rate_sample    (req_rate_sample),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_compute_level  (rsp_compute_level),
      .rsp_floor_breached (rsp_floor_breached),
      .rsp_average_rate   (rsp_average_rate)
   );

endmodule

`default_nettype wire

[design/tgls_checker.sv]
// Port-level checker for the throughput guard level selector, attached to
// the top level by bind. Depends on tgls_pkg.
`default_nettype none

module tgls_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic [1:0]                      rsp_compute_level,
   input wire logic                            rsp_floor_breached,
   input wire logic [tgls_pkg::RATE_WIDTH-1:0] rsp_average_rate
);
   import tgls_pkg::*;

   logic       req_take, rsp_take;
   logic [1:0] open_ff, open_in;
   logic       seen_breach_ff;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   // Outstanding transactions
   always_comb begin
      open_in = open_ff;
      if (req_take && !rsp_take && open_ff != 2'd3) begin
         open_in = open_ff + 2'd1;
      end else if (!req_take && rsp_take && open_ff != 2'd0) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff        <= '0;
         seen_breach_ff <= 1'b0;
      end else begin
         open_ff <= open_in;
         if (rsp_take && rsp_floor_breached) begin
            seen_breach_ff <= 1'b1;
         end
      end
   end

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_compute_level)
         && $stable(rsp_floor_breached) && $stable(rsp_average_rate))
      else $error("stalled result changed");

   // Every result answers an earlier request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("result without a request");

   // Skip is only chosen on a breach
   a_skip_breach: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compute_level == LEVEL_SKIP |-> rsp_floor_breached)
      else $error("skip level without breach flag");

   // Breach flag is sticky across results
   a_breach_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_breach_ff |-> rsp_floor_breached)
      else $error("breach flag cleared");

endmodule

bind throughput_guard_level_select tgls_checker u_tgls_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_compute_level  (rsp_compute_level),
   .rsp_floor_breached (rsp_floor_breached),
   .rsp_average_rate   (rsp_average_rate)
);

`default_nettype wire
